// ===== rtl/prbp_pkg.sv =====
// prbp_pkg: shared types and constants for the plane rotation block
// holds the cordic angle table, the inverse gain and the cell beat type
// no dependencies
package prbp_pkg;

   localparam int COORD_W      = 16;
   localparam int ACC_W        = 32;
   localparam int ATAN_ENTRIES = 24;

   // 1/K in Q30, starting cosine of every rotation
   localparam logic signed [ACC_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic signed [ACC_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   // quadrant of the requested angle, in quarter turns
   typedef enum logic [1:0] {
      QUAD_ZERO,
      QUAD_ONE,
      QUAD_TWO,
      QUAD_THREE
   } quad_type;

   // one beat moving along the cell chain
   typedef struct packed {
      logic signed [ACC_W-1:0]   cos_acc;
      logic signed [ACC_W-1:0]   sin_acc;
      logic signed [ACC_W-1:0]   ang_res;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      quad_type                  quad;
   } cell_data_type;

endpackage

// ===== rtl/prbp_cell.sv =====
// prbp_cell: one cordic micro-rotation cell with its own beat register
// depends on prbp_pkg for the angle table and the beat type
module prbp_cell
   import prbp_pkg::*;
#(
   parameter int STAGE_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  cell_data_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output cell_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic signed [ACC_W-1:0] delta_c;
   logic signed [ACC_W-1:0] delta_s;

   // take a new beat when empty or when the held one leaves
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // micro-rotation toward a zero residual angle
   always_comb begin
      delta_c = in_data.sin_acc >>> STAGE_INDEX;
      delta_s = in_data.cos_acc >>> STAGE_INDEX;
      data_in = in_data;
      if (!in_data.ang_res[ACC_W-1]) begin
         data_in.cos_acc = in_data.cos_acc - delta_c;
         data_in.sin_acc = in_data.sin_acc + delta_s;
         data_in.ang_res = in_data.ang_res - ATAN_TURN32[STAGE_INDEX];
      end else begin
         data_in.cos_acc = in_data.cos_acc + delta_c;
         data_in.sin_acc = in_data.sin_acc - delta_s;
         data_in.ang_res = in_data.ang_res + ATAN_TURN32[STAGE_INDEX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/prbp_mix.sv =====
// prbp_mix: quadrant fold, coordinate products and round/saturate output stage
// depends on prbp_pkg; its second register is the result channel register
module prbp_mix
   import prbp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  cell_data_type             in_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_rot_x,
   output logic signed [COORD_W-1:0] rsp_rot_y,
   output logic signed [COORD_W-1:0] rsp_out_z
);

   localparam int PROD_W  = COORD_W + ACC_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int FRAC_W  = 30;
   localparam int SHIFT_W = SUM_W - FRAC_W;

   localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [SHIFT_W-1:0] SAT_MAX    = SHIFT_W'(32767);
   localparam logic signed [SHIFT_W-1:0] SAT_MIN    = -SHIFT_W'(32768);

   logic                      prod_valid_ff;
   logic                      prod_valid_in;
   logic                      prod_ready;
   logic signed [PROD_W-1:0]  prod_xc_ff, prod_xc_in;
   logic signed [PROD_W-1:0]  prod_ys_ff, prod_ys_in;
   logic signed [PROD_W-1:0]  prod_xs_ff, prod_xs_in;
   logic signed [PROD_W-1:0]  prod_yc_ff, prod_yc_in;
   logic signed [COORD_W-1:0] prod_z_ff;
   logic signed [ACC_W-1:0]   cos_sel;
   logic signed [ACC_W-1:0]   sin_sel;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_ready;
   logic signed [COORD_W-1:0] rot_x_ff, rot_x_in;
   logic signed [COORD_W-1:0] rot_y_ff, rot_y_in;
   logic signed [COORD_W-1:0] out_z_ff;
   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;
   logic signed [SHIFT_W-1:0] shr_x;
   logic signed [SHIFT_W-1:0] shr_y;

   // stage handshakes
   assign out_ready     = !out_valid_ff || rsp_ready;
   assign prod_ready    = !prod_valid_ff || out_ready;
   assign in_ready      = prod_ready;
   assign prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
   assign out_valid_in  = out_ready ? prod_valid_ff : out_valid_ff;

   // unfold the residual cosine and sine into the quadrant of the angle
   always_comb begin
      unique case (in_data.quad)
         QUAD_ZERO: begin
            cos_sel = in_data.cos_acc;
            sin_sel = in_data.sin_acc;
         end
         QUAD_ONE: begin
            cos_sel = -in_data.sin_acc;
            sin_sel = in_data.cos_acc;
         end
         QUAD_TWO: begin
            cos_sel = -in_data.cos_acc;
            sin_sel = -in_data.sin_acc;
         end
         default: begin
            cos_sel = in_data.sin_acc;
            sin_sel = -in_data.cos_acc;
         end
      endcase
      prod_xc_in = PROD_W'(in_data.pos_x) * PROD_W'(cos_sel);
      prod_ys_in = PROD_W'(in_data.pos_y) * PROD_W'(sin_sel);
      prod_xs_in = PROD_W'(in_data.pos_x) * PROD_W'(sin_sel);
      prod_yc_in = PROD_W'(in_data.pos_y) * PROD_W'(cos_sel);
   end

   // combine Q44 products, round to Q14 and saturate
   always_comb begin
      sum_x = SUM_W'(prod_xc_ff) - SUM_W'(prod_ys_ff) + ROUND_HALF;
      sum_y = SUM_W'(prod_xs_ff) + SUM_W'(prod_yc_ff) + ROUND_HALF;
      shr_x = sum_x[SUM_W-1:FRAC_W];
      shr_y = sum_y[SUM_W-1:FRAC_W];
      priority if (shr_x > SAT_MAX) begin
         rot_x_in = COORD_W'(SAT_MAX);
      end else if (shr_x < SAT_MIN) begin
         rot_x_in = COORD_W'(SAT_MIN);
      end else begin
         rot_x_in = shr_x[COORD_W-1:0];
      end
      priority if (shr_y > SAT_MAX) begin
         rot_y_in = COORD_W'(SAT_MAX);
      end else if (shr_y < SAT_MIN) begin
         rot_y_in = COORD_W'(SAT_MIN);
      end else begin
         rot_y_in = shr_y[COORD_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // product registers
   always_ff @(posedge clock) begin
      if (in_valid && prod_ready) begin
         prod_xc_ff <= prod_xc_in;
         prod_ys_ff <= prod_ys_in;
         prod_xs_ff <= prod_xs_in;
         prod_yc_ff <= prod_yc_in;
         prod_z_ff  <= in_data.pos_z;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (prod_valid_ff && out_ready) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         out_z_ff <= prod_z_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rot_x = rot_x_ff;
   assign rsp_rot_y = rot_y_ff;
   assign rsp_out_z = out_z_ff;

endmodule

// ===== rtl/plane_rotation_by_phase.sv =====
// plane_rotation_by_phase: rotates (x, y) about z by minus phase times two pi
// depends on prbp_pkg, prbp_cell (cordic chain) and prbp_mix (products, output)
//
//   channel   ports                                         direction
//   request   req_valid req_ready req_pos_x/y/z req_turn_phase   in
//   response  rsp_valid rsp_ready rsp_rot_x rsp_rot_y rsp_out_z  out
//
// one beat per cycle while rsp_ready is high; a beat passes one register per
// cordic cell, then the product register, then the round-and-saturate register.
// every stage holds its own valid bit, cleared by reset; an empty stage is
// filled even while later stages are stalled, so bubbles squeeze out.
// rsp_ready low holds the result register and backs up the chain stage by stage.
module plane_rotation_by_phase
   import prbp_pkg::*;
#(
   parameter int ROTATION_STAGES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic        [COORD_W-1:0] req_turn_phase,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_rot_x,
   output logic signed [COORD_W-1:0] rsp_rot_y,
   output logic signed [COORD_W-1:0] rsp_out_z
);

   localparam int QUAD_LSB = COORD_W - 2;

   logic [COORD_W-1:0] phi;
   logic [COORD_W-1:0] phi_bias;
   logic [1:0]         quad_bits;
   logic [COORD_W-1:0] resid;

   cell_data_type chain_data  [ROTATION_STAGES+1];
   logic          chain_valid [ROTATION_STAGES+1];
   logic          chain_ready [ROTATION_STAGES+1];

   // split the negated phase into a quadrant and a signed residual
   always_comb begin
      phi       = COORD_W'(0) - req_turn_phase;
      phi_bias  = phi + (COORD_W'(1) << (QUAD_LSB - 1));
      quad_bits = phi_bias[COORD_W-1:QUAD_LSB];
      resid     = phi - {quad_bits, QUAD_LSB'(0)};
      chain_data[0].cos_acc = INV_GAIN_Q30;
      chain_data[0].sin_acc = '0;
      chain_data[0].ang_res = {resid, (ACC_W - COORD_W)'(0)};
      chain_data[0].pos_x   = req_pos_x;
      chain_data[0].pos_y   = req_pos_y;
      chain_data[0].pos_z   = req_pos_z;
      chain_data[0].quad    = quad_type'(quad_bits);
   end

   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // cordic cell chain
   for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
      prbp_cell #(
         .STAGE_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (chain_valid[g]),
         .in_ready (chain_ready[g]),
         .in_data  (chain_data[g]),
         .out_valid(chain_valid[g+1]),
         .out_ready(chain_ready[g+1]),
         .out_data (chain_data[g+1])
      );
   end

   // products and output register
   prbp_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[ROTATION_STAGES]),
      .in_ready (chain_ready[ROTATION_STAGES]),
      .in_data  (chain_data[ROTATION_STAGES]),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rot_x(rsp_rot_x),
      .rsp_rot_y(rsp_rot_y),
      .rsp_out_z(rsp_out_z)
   );

`ifndef SYNTHESIS
   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty result register lets the whole chain move
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // a draining consumer never stalls the producer
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while result drains");
`endif

endmodule
